/* sv/hsbc_pkg.sv */
`timescale 1ns / 1ps

package hsbc_pkg;

    // Sizes
    localparam int MAX_PLANES = 256;
    localparam int SLOT_COUNT = 512;
    localparam int LEVEL_BITS = 32;
    localparam int PLANE_AW   = $clog2(MAX_PLANES);
    localparam int SLOT_AW    = $clog2(SLOT_COUNT);
    localparam int SLOT_CW    = SLOT_AW + 1;
    localparam int COUNT_W    = PLANE_AW + 1;

    // Action codes
    localparam logic [1:0] ACT_LOAD     = 2'd0;
    localparam logic [1:0] ACT_BUILD    = 2'd1;
    localparam logic [1:0] ACT_CLASSIFY = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_RISING = 2'd1;
    localparam logic [1:0] ST_NOT_BUILT  = 2'd2;
    localparam logic [1:0] ST_ON_PLANE   = 2'd3;

    typedef struct packed {
        logic [1:0]                   action;
        logic [7:0]                   plane_slot;
        logic signed [LEVEL_BITS-1:0] plane_level;
        logic signed [LEVEL_BITS-1:0] origin_level;
        logic signed [LEVEL_BITS-1:0] dest_level;
        logic [15:0]                  arc_number;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        listed;
        logic [7:0]  bucket;
        logic [15:0] arc_out;
        logic [8:0]  search_steps;
    } t_result;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHK_RD,
        S_CHK_USE,
        S_HASH_RD,
        S_HASH_SET,
        S_GROUP,
        S_NEXT,
        S_FLUSH,
        S_FILL,
        S_MUL,
        S_DIV,
        S_ENTRY,
        S_SLOT_RD,
        S_SLOT_USE,
        S_FW_RD,
        S_FW_USE,
        S_BW_RD,
        S_BW_USE,
        S_CHECK
    } t_state;

endpackage

/* sv/hashed_slab_bucket_classifier.sv */
`timescale 1ns / 1ps

// Channel    Direction  Transfer when         Payload
// command    in         i_start & !o_busy     i_item   (hsbc_pkg::t_item)
// result     out        o_done (one cycle)    o_result (hsbc_pkg::t_result)
// config     in         i_cfg_we              i_cfg_data (plane_count)
//
// Load and unused items: result in the cycle after the transfer, no busy time.
// Build: a rising check read per plane, then for each plane after the first
// the hash (read, one multiply, a 10-step restoring divider, group, next),
// plus the slot writes of the fill sweep and one or two flush passes.
// Classify: hash and slot read, then a read and a compare per plane looked
// at in the search (the single-port plane memory read sets the step time),
// then the check, skipped if out of range; below the lowest plane, no search.
// Reset is synchronous, active low; memories are not cleared. Results
// cannot be stalled: o_done is a one-cycle strobe.
module hashed_slab_bucket_classifier (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  hsbc_pkg::t_item  i_item,
    input  logic             i_cfg_we,
    input  logic [8:0]       i_cfg_data,
    output logic             o_done,
    output hsbc_pkg::t_result o_result
);

    localparam int AW = hsbc_pkg::PLANE_AW;
    localparam int SW = hsbc_pkg::SLOT_AW;
    localparam int CW = hsbc_pkg::SLOT_CW;
    localparam int LB = hsbc_pkg::LEVEL_BITS;
    localparam int RW = CW + LB + 3;

    // Memories
    logic signed [LB-1:0] plane_mem [hsbc_pkg::MAX_PLANES];
    logic [AW-1:0]        slot_mem  [hsbc_pkg::SLOT_COUNT];
    logic signed [LB-1:0] r_prd;
    logic [AW-1:0]        r_srd;

    // Control and datapath registers
    hsbc_pkg::t_state     r_state, n_state;
    logic [8:0]           r_np;
    logic                 r_ready, n_ready;
    logic [LB:0]          r_span, n_span;
    logic signed [LB-1:0] r_zlo, n_zlo, r_zhi, n_zhi;
    logic signed [LB-1:0] r_zo, n_zo, r_zd, n_zd;
    logic [15:0]          r_arc, n_arc;
    logic [AW-1:0]        r_ip, n_ip;
    logic [8:0]           r_steps, n_steps;
    logic signed [LB-1:0] r_cur, n_cur, r_prev, n_prev;
    logic                 r_have_prev, n_have_prev;
    logic signed [LB-1:0] r_hz, n_hz;
    logic                 r_hret, n_hret;
    logic [RW-1:0]        r_rem, n_rem;
    logic [CW-1:0]        r_q, n_q;
    logic [3:0]           r_dc, n_dc;
    logic [CW-1:0]        r_ha, n_ha, r_hb, n_hb;
    logic [AW-1:0]        r_va, n_va, r_vb, n_vb;
    logic                 r_have_a, n_have_a;
    logic [CW-1:0]        r_fs, n_fs, r_fend, n_fend, r_split, n_split;
    logic [AW-1:0]        r_fva, n_fva, r_fvb, n_fvb;
    logic                 r_ftail, n_ftail;
    logic                 r_done, n_done;
    hsbc_pkg::t_result    r_res, n_res;

    // Combinational helpers
    logic                 w_accept;
    logic                 w_pwe, w_swe;
    logic [AW-1:0]        w_paddr, w_sdata;
    logic [CW-1:0]        w_nh;
    logic [AW-1:0]        w_last;
    logic                 w_is_last, w_chk_fail, w_hash_zero, w_take;
    logic                 w_in_range, w_fw_go, w_bw_go, w_fill_end;
    logic signed [LB-1:0] w_zlo_eff;
    logic [LB:0]          w_d33;
    logic [CW+LB-1:0]     w_prod;
    logic [RW-1:0]        w_dshift;
    logic [CW-1:0]        w_qn, w_qclamp, w_gap;
    logic [8:0]           w_cfg;

    assign w_accept   = i_start && (r_state == hsbc_pkg::S_IDLE);
    assign w_pwe      = w_accept && (i_item.action == hsbc_pkg::ACT_LOAD);
    assign w_nh       = ({r_np, 1'b0} > CW'(hsbc_pkg::SLOT_COUNT))
                        ? CW'(hsbc_pkg::SLOT_COUNT) : CW'({r_np, 1'b0});
    assign w_last     = AW'(r_np - 9'd1);
    assign w_is_last  = (r_ip == w_last);
    assign w_chk_fail = (r_ip != '0) && (r_prd <= r_prev);
    assign w_zlo_eff  = (r_ip == '0) ? r_prd : r_zlo;
    assign w_hash_zero = (r_hz <= r_zlo) || (r_span == '0);
    assign w_d33      = {r_hz[LB-1], r_hz} - {r_zlo[LB-1], r_zlo};
    assign w_prod     = {w_nh, 1'b0} * w_d33[LB-1:0];
    assign w_dshift   = RW'({r_span, 1'b0}) << r_dc;
    assign w_take     = (r_rem >= w_dshift);
    assign w_qn       = r_q | (w_take ? (CW'(1) << r_dc) : CW'(0));
    assign w_qclamp   = (w_qn >= w_nh) ? (w_nh - CW'(1)) : w_qn;
    assign w_gap      = r_hb - r_ha - CW'(1);
    assign w_in_range = (r_zo < r_zd) && (r_zo < r_zhi) && (r_zd > r_zlo);
    assign w_fw_go    = !w_is_last && (r_zo > r_prd);
    assign w_bw_go    = (r_zo < r_prd);
    assign w_fill_end = ((r_fs + CW'(1)) == r_fend);
    assign w_cfg      = (i_cfg_data == '0) ? 9'd1
                        : ((i_cfg_data > 9'(hsbc_pkg::MAX_PLANES))
                           ? 9'(hsbc_pkg::MAX_PLANES) : i_cfg_data);

    // Outputs and memory control
    always_comb begin
        o_busy   = (r_state != hsbc_pkg::S_IDLE);
        o_done   = r_done;
        o_result = r_res;
        w_swe    = (r_state == hsbc_pkg::S_FILL);
        w_sdata  = (r_fs < r_split) ? r_fva : r_fvb;
        unique case (r_state)
            hsbc_pkg::S_BW_RD: w_paddr = r_ip - AW'(1);
            default:           w_paddr = r_ip;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hsbc_pkg::S_IDLE: begin
                if (w_accept && i_item.action == hsbc_pkg::ACT_BUILD) begin
                    n_state = hsbc_pkg::S_CHK_RD;
                end else if (w_accept && i_item.action == hsbc_pkg::ACT_CLASSIFY
                             && r_ready) begin
                    n_state = hsbc_pkg::S_ENTRY;
                end
            end
            hsbc_pkg::S_CHK_RD: n_state = hsbc_pkg::S_CHK_USE;
            hsbc_pkg::S_CHK_USE: begin
                if (w_chk_fail) begin
                    n_state = hsbc_pkg::S_IDLE;
                end else if (w_is_last) begin
                    n_state = (r_np == 9'd1) ? hsbc_pkg::S_FILL : hsbc_pkg::S_HASH_RD;
                end else begin
                    n_state = hsbc_pkg::S_CHK_RD;
                end
            end
            hsbc_pkg::S_HASH_RD:  n_state = hsbc_pkg::S_HASH_SET;
            hsbc_pkg::S_HASH_SET: n_state = hsbc_pkg::S_MUL;
            hsbc_pkg::S_GROUP: begin
                n_state = (r_q != r_hb && r_have_a) ? hsbc_pkg::S_FILL : hsbc_pkg::S_NEXT;
            end
            hsbc_pkg::S_NEXT: begin
                n_state = w_is_last ? hsbc_pkg::S_FLUSH : hsbc_pkg::S_HASH_RD;
            end
            hsbc_pkg::S_FLUSH: n_state = hsbc_pkg::S_FILL;
            hsbc_pkg::S_FILL: begin
                if (w_fill_end) begin
                    n_state = r_ftail ? hsbc_pkg::S_IDLE : hsbc_pkg::S_NEXT;
                end
            end
            hsbc_pkg::S_MUL: begin
                if (w_hash_zero) begin
                    n_state = r_hret ? hsbc_pkg::S_SLOT_RD : hsbc_pkg::S_GROUP;
                end else begin
                    n_state = hsbc_pkg::S_DIV;
                end
            end
            hsbc_pkg::S_DIV: begin
                if (r_dc == '0) begin
                    n_state = r_hret ? hsbc_pkg::S_SLOT_RD : hsbc_pkg::S_GROUP;
                end
            end
            hsbc_pkg::S_ENTRY: begin
                if (!w_in_range) begin
                    n_state = hsbc_pkg::S_IDLE;
                end else if (r_zo >= r_zlo) begin
                    n_state = hsbc_pkg::S_MUL;
                end else begin
                    n_state = hsbc_pkg::S_CHECK;
                end
            end
            hsbc_pkg::S_SLOT_RD:  n_state = hsbc_pkg::S_SLOT_USE;
            hsbc_pkg::S_SLOT_USE: n_state = hsbc_pkg::S_FW_RD;
            hsbc_pkg::S_FW_RD:    n_state = hsbc_pkg::S_FW_USE;
            hsbc_pkg::S_FW_USE: begin
                if (w_fw_go) begin
                    n_state = hsbc_pkg::S_FW_RD;
                end else if (r_ip != '0) begin
                    n_state = hsbc_pkg::S_BW_RD;
                end else begin
                    n_state = hsbc_pkg::S_CHECK;
                end
            end
            hsbc_pkg::S_BW_RD: n_state = hsbc_pkg::S_BW_USE;
            hsbc_pkg::S_BW_USE: begin
                n_state = (w_bw_go && r_ip > AW'(1)) ? hsbc_pkg::S_BW_RD
                                                       : hsbc_pkg::S_CHECK;
            end
            hsbc_pkg::S_CHECK: n_state = hsbc_pkg::S_IDLE;
            default:           n_state = hsbc_pkg::S_IDLE;
        endcase
    end

    // Datapath next values
    always_comb begin
        n_ready = r_ready;     n_span = r_span;       n_zlo = r_zlo;
        n_zhi = r_zhi;         n_zo = r_zo;           n_zd = r_zd;
        n_arc = r_arc;         n_ip = r_ip;           n_steps = r_steps;
        n_cur = r_cur;         n_prev = r_prev;       n_have_prev = r_have_prev;
        n_hz = r_hz;           n_hret = r_hret;       n_rem = r_rem;
        n_q = r_q;             n_dc = r_dc;           n_ha = r_ha;
        n_hb = r_hb;           n_va = r_va;           n_vb = r_vb;
        n_have_a = r_have_a;   n_fs = r_fs;           n_fend = r_fend;
        n_split = r_split;     n_fva = r_fva;         n_fvb = r_fvb;
        n_ftail = r_ftail;
        n_done = 1'b0;
        n_res  = r_res;
        case (r_state)
            hsbc_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_zo    = i_item.origin_level;
                    n_zd    = i_item.dest_level;
                    n_arc   = i_item.arc_number;
                    n_ip    = '0;
                    n_steps = '0;
                    n_res   = '0;
                    unique case (i_item.action)
                        hsbc_pkg::ACT_LOAD: begin
                            n_ready = 1'b0;
                            n_done  = 1'b1;
                        end
                        hsbc_pkg::ACT_BUILD: ;
                        hsbc_pkg::ACT_CLASSIFY: begin
                            if (!r_ready) begin
                                n_done         = 1'b1;
                                n_res.status   = hsbc_pkg::ST_NOT_BUILT;
                                n_res.arc_out  = i_item.arc_number;
                            end
                        end
                        default: n_done = 1'b1;
                    endcase
                end
            end
            // Rising check, capture end heights and span
            hsbc_pkg::S_CHK_USE: begin
                n_prev = r_prd;
                if (r_ip == '0) n_zlo = r_prd;
                if (w_chk_fail) begin
                    n_done       = 1'b1;
                    n_res        = '0;
                    n_res.status = hsbc_pkg::ST_NOT_RISING;
                end else if (w_is_last) begin
                    n_zhi    = r_prd;
                    n_span   = {r_prd[LB-1], r_prd} - {w_zlo_eff[LB-1], w_zlo_eff};
                    n_hb     = '0;
                    n_vb     = '0;
                    n_have_a = 1'b0;
                    n_ip     = AW'(1);
                    // single plane: whole table maps to plane 0
                    n_fs     = '0;
                    n_fend   = w_nh;
                    n_split  = w_nh;
                    n_fva    = '0;
                    n_fvb    = '0;
                    n_ftail  = 1'b1;
                end else begin
                    n_ip = r_ip + AW'(1);
                end
            end
            hsbc_pkg::S_HASH_SET: begin
                n_hz   = r_prd;
                n_hret = 1'b0;
            end
            // A new defined slot closes the previous group; a repeat slot takes the later plane
            hsbc_pkg::S_GROUP: begin
                if (r_q == r_hb) begin
                    n_vb = r_ip;
                end else begin
                    n_fs     = r_ha;
                    n_fend   = r_hb;
                    n_split  = r_ha + CW'(1) + (w_gap >> 1);
                    n_fva    = r_va;
                    n_fvb    = r_vb;
                    n_ftail  = 1'b0;
                    n_ha     = r_hb;
                    n_va     = r_vb;
                    n_hb     = r_q;
                    n_vb     = r_ip;
                    n_have_a = 1'b1;
                end
            end
            hsbc_pkg::S_NEXT: begin
                if (!w_is_last) n_ip = r_ip + AW'(1);
            end
            // Last gap, then the tail after the last defined slot
            hsbc_pkg::S_FLUSH: begin
                if (r_have_a) begin
                    n_fs     = r_ha;
                    n_fend   = r_hb;
                    n_split  = r_ha + CW'(1) + (w_gap >> 1);
                    n_fva    = r_va;
                    n_fvb    = r_vb;
                    n_ftail  = 1'b0;
                    n_have_a = 1'b0;
                end else begin
                    n_fs    = r_hb;
                    n_fend  = w_nh;
                    n_split = w_nh;
                    n_fva   = r_vb;
                    n_fvb   = r_vb;
                    n_ftail = 1'b1;
                end
            end
            hsbc_pkg::S_FILL: begin
                n_fs = r_fs + CW'(1);
                if (w_fill_end && r_ftail) begin
                    n_ready = 1'b1;
                    n_done  = 1'b1;
                    n_res   = '0;
                end
            end
            // Hash: numerator product, then restoring division
            hsbc_pkg::S_MUL: begin
                n_q  = '0;
                n_dc = 4'(CW - 1);
                n_rem = {{(RW-CW-LB){1'b0}}, w_prod} + RW'(r_span);
            end
            hsbc_pkg::S_DIV: begin
                if (w_take) n_rem = r_rem - w_dshift;
                n_q  = (r_dc == '0) ? w_qclamp : w_qn;
                n_dc = r_dc - 4'd1;
            end
            hsbc_pkg::S_ENTRY: begin
                if (!w_in_range) begin
                    n_done        = 1'b1;
                    n_res         = '0;
                    n_res.arc_out = r_arc;
                    if (r_zo < r_zd && (r_zo == r_zhi || r_zd == r_zlo))
                        n_res.status = hsbc_pkg::ST_ON_PLANE;
                end else if (r_zo >= r_zlo) begin
                    n_hz   = r_zo;
                    n_hret = 1'b1;
                end else begin
                    n_ip        = '0;
                    n_cur       = r_zlo;
                    n_have_prev = 1'b0;
                end
            end
            hsbc_pkg::S_SLOT_USE: begin
                n_ip = (r_srd > w_last) ? w_last : r_srd;
            end
            hsbc_pkg::S_FW_USE: begin
                n_cur       = r_prd;
                n_have_prev = 1'b0;
                if (w_fw_go) begin
                    n_ip    = r_ip + AW'(1);
                    n_steps = r_steps + 9'd1;
                end
            end
            hsbc_pkg::S_BW_USE: begin
                if (w_bw_go) begin
                    n_ip        = r_ip - AW'(1);
                    n_steps     = r_steps + 9'd1;
                    n_cur       = r_prd;
                    n_have_prev = 1'b0;
                end else begin
                    n_prev      = r_prd;
                    n_have_prev = 1'b1;
                end
            end
            // Vertex checks and bucket decision
            hsbc_pkg::S_CHECK: begin
                n_done             = 1'b1;
                n_res              = '0;
                n_res.arc_out      = r_arc;
                n_res.bucket       = 8'(r_ip);
                n_res.search_steps = r_steps;
                if (r_zo == r_cur || (r_have_prev && r_zo == r_prev)) begin
                    n_res.status = hsbc_pkg::ST_ON_PLANE;
                end else if (r_zd > r_cur) begin
                    n_res.listed = 1'b1;
                end else if (r_zd == r_cur) begin
                    n_res.status = hsbc_pkg::ST_ON_PLANE;
                end
            end
            default: ;
        endcase
    end

    // Plane memory: write on load transfer, registered read
    always_ff @(posedge i_clk) begin
        if (w_pwe) begin
            plane_mem[i_item.plane_slot[AW-1:0]] <= i_item.plane_level;
        end
        r_prd <= plane_mem[w_paddr];
    end

    // Slot memory: written by the fill sweep, registered read at hash result
    always_ff @(posedge i_clk) begin
        if (w_swe) begin
            slot_mem[r_fs[SW-1:0]] <= w_sdata;
        end
        r_srd <= slot_mem[r_q[SW-1:0]];
    end

    // Control registers; a count write drops the built table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hsbc_pkg::S_IDLE;
            r_np    <= 9'd1;
            r_ready <= 1'b0;
            r_span  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_span  <= n_span;
            r_done  <= n_done;
            r_ready <= n_ready && !i_cfg_we;
            if (i_cfg_we) begin
                r_np <= w_cfg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_zlo <= n_zlo;   r_zhi <= n_zhi;   r_zo <= n_zo;     r_zd <= n_zd;
        r_arc <= n_arc;   r_ip <= n_ip;     r_steps <= n_steps;
        r_cur <= n_cur;   r_prev <= n_prev; r_have_prev <= n_have_prev;
        r_hz <= n_hz;     r_hret <= n_hret; r_rem <= n_rem;   r_q <= n_q;
        r_dc <= n_dc;     r_ha <= n_ha;     r_hb <= n_hb;     r_va <= n_va;
        r_vb <= n_vb;     r_have_a <= n_have_a;
        r_fs <= n_fs;     r_fend <= n_fend; r_split <= n_split;
        r_fva <= n_fva;   r_fvb <= n_fvb;   r_ftail <= n_ftail;
        r_res <= n_res;
    end

endmodule
